>>> src/rhd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relative humidity package
// Shared widths, constants, reciprocal table and flag types of the
// relative humidity from dewpoint pipeline.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int TEMP_FRAC_BITS_DEF = 8;
  localparam int IN_W               = 17;
  localparam int PCT_W              = 14;

  localparam int KELVIN_X100  = 27315;
  localparam int MAGNUS_B_X10 = 2373;
  localparam int MAGNUS_A_X100 = 1727;
  localparam int A_W          = 11;
  localparam int SCALE        = 100;
  localparam int SCALE_W      = 7;
  // Floor of log2 of SCALE, the least quotient headroom the divider gains.
  localparam int SCALE_LOG2   = 6;

  localparam int Q_EXP  = 24;
  localparam int U_W    = 28;
  localparam int N_W    = 5;
  localparam logic [31:0] LN2_Q24 = 32'd11629080;

  localparam int Q_TERM   = 30;
  localparam int TERM_W   = 31;
  localparam int R_W      = 30;
  localparam int SUM_W    = 33;
  localparam int Y_W      = 63;
  localparam int TAYLOR_N = 12;
  localparam logic [TERM_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;

  localparam int FRONT_STAGES = 3;
  localparam int DIFF_STAGES  = 2;
  localparam int EXP_STAGES   = N_W + 2 * TAYLOR_N + 4;

  // Floor division by k is a multiply by RECIP_M[k-1] and a shift by
  // RECIP_SH[k-1]; exact for dividends below 2^31.
  localparam logic [31:0] RECIP_M [TAYLOR_N] = '{
    32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648,
    32'd3435973837, 32'd2863311531, 32'd2454267027, 32'd2147483648,
    32'd3817748708, 32'd3435973837, 32'd3123612579, 32'd2863311531
  };
  localparam int RECIP_SH [TAYLOR_N] = '{
    31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35
  };

  typedef struct packed {
    logic miss;
    logic full;
    logic zero;
  } flags_t;

  function automatic logic [63:0] kelvin_offset(input int f);
    return ((64'(KELVIN_X100) << f) + 64'd50) / 64'd100;
  endfunction

  function automatic logic [63:0] magnus_offset(input int f);
    return ((64'(MAGNUS_B_X10) << f) + 64'd5) / 64'd10;
  endfunction

  function automatic int mag_width(input int f);
    int kw;
    kw = $clog2(kelvin_offset(f) + 64'd1);
    return (kw > IN_W) ? kw : IN_W;
  endfunction

  function automatic int quo_width(input int f);
    return mag_width(f) + A_W + Q_EXP + 1 - SCALE_LOG2;
  endfunction

  function automatic int latency(input int f);
    return FRONT_STAGES + quo_width(f) + DIFF_STAGES + EXP_STAGES;
  endfunction

endpackage
`default_nettype wire

>>> src/rhd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division with one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rhd_div #(
  parameter int NW = 53,
  parameter int DW = 24,
  parameter int QW = 47,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [TW-1:0]      out_tag
);

  logic          v_r   [QW];
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    assign ge      = (rem_in >> B) >= NW'(den_in);
    assign rem_nxt = ge ? (rem_in - (NW'(den_in) << B)) : rem_in;
    assign quo_nxt = quo_in | (QW'(ge) << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_in;
      quo_r[s] <= quo_nxt;
      tag_r[s] <= tag_in;
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule
`default_nettype wire

>>> src/rhd_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Negative exponential pipeline
// Range reduction by ln 2, a Taylor series in Q30, scaling to hundredths
// of a percent and the final result selection.
// ----------------------------------------------------------------------------
module rhd_exp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [rhd_pkg::U_W-1:0]  in_u,
  input  wire rhd_pkg::flags_t          in_flags,
  output logic                          out_valid,
  output logic [rhd_pkg::PCT_W-1:0]     out_pct,
  output logic                          out_missing
);

  localparam int U_W    = rhd_pkg::U_W;
  localparam int N_W    = rhd_pkg::N_W;
  localparam int R_W    = rhd_pkg::R_W;
  localparam int TERM_W = rhd_pkg::TERM_W;
  localparam int SUM_W  = rhd_pkg::SUM_W;
  localparam int Y_W    = rhd_pkg::Y_W;
  localparam int T      = rhd_pkg::TAYLOR_N;
  localparam int P_W    = TERM_W + R_W;
  localparam int RES_W  = SUM_W + rhd_pkg::PCT_W;
  localparam int PR_W   = 18;

  logic                  rd_v_r   [N_W];
  logic [U_W-1:0]        rd_rem_r [N_W];
  logic [N_W-1:0]        rd_n_r   [N_W];
  rhd_pkg::flags_t       rd_f_r   [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_red
    localparam int B = N_W - 1 - s;
    logic            v_in;
    logic [U_W-1:0]  rem_in;
    logic [N_W-1:0]  n_in;
    rhd_pkg::flags_t f_in;
    logic [U_W-1:0]  step;
    logic            ge;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_u;
      assign n_in   = '0;
      assign f_in   = in_flags;
    end else begin : g_next
      assign v_in   = rd_v_r[s-1];
      assign rem_in = rd_rem_r[s-1];
      assign n_in   = rd_n_r[s-1];
      assign f_in   = rd_f_r[s-1];
    end

    assign step = U_W'(rhd_pkg::LN2_Q24 << B);
    assign ge   = rem_in >= step;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rd_v_r[s] <= 1'b0;
      end else begin
        rd_v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rd_rem_r[s] <= ge ? (rem_in - step) : rem_in;
      rd_n_r[s]   <= n_in | (N_W'(ge) << B);
      rd_f_r[s]   <= f_in;
    end
  end

  logic                  ta_v_r   [T];
  logic [TERM_W-1:0]     ta_x_r   [T];
  logic [SUM_W-1:0]      ta_pos_r [T];
  logic [SUM_W-1:0]      ta_neg_r [T];
  logic [R_W-1:0]        ta_r_r   [T];
  logic [N_W-1:0]        ta_n_r   [T];
  rhd_pkg::flags_t       ta_f_r   [T];

  logic                  tb_v_r   [T];
  logic [Y_W-1:0]        tb_y_r   [T];
  logic [SUM_W-1:0]      tb_pos_r [T];
  logic [SUM_W-1:0]      tb_neg_r [T];
  logic [R_W-1:0]        tb_r_r   [T];
  logic [N_W-1:0]        tb_n_r   [T];
  rhd_pkg::flags_t       tb_f_r   [T];

  for (genvar j = 0; j < T; j++) begin : g_term
    logic              v_in;
    logic [TERM_W-1:0] term_in;
    logic [SUM_W-1:0]  pos_in;
    logic [SUM_W-1:0]  neg_in;
    logic [R_W-1:0]    r_in;
    logic [N_W-1:0]    n_in;
    rhd_pkg::flags_t   f_in;

    if (j == 0) begin : g_first
      assign v_in    = rd_v_r[N_W-1];
      assign term_in = rhd_pkg::ONE_Q30;
      assign pos_in  = SUM_W'(rhd_pkg::ONE_Q30);
      assign neg_in  = '0;
      assign r_in    = R_W'(rd_rem_r[N_W-1]) << (R_W - rhd_pkg::Q_EXP);
      assign n_in    = rd_n_r[N_W-1];
      assign f_in    = rd_f_r[N_W-1];
    end else begin : g_next
      assign v_in    = tb_v_r[j-1];
      assign term_in = TERM_W'(tb_y_r[j-1] >> rhd_pkg::RECIP_SH[j-1]);
      assign r_in    = tb_r_r[j-1];
      assign n_in    = tb_n_r[j-1];
      assign f_in    = tb_f_r[j-1];
      if (j % 2 == 1) begin : g_odd
        assign pos_in = tb_pos_r[j-1];
        assign neg_in = tb_neg_r[j-1] + SUM_W'(term_in);
      end else begin : g_even
        assign pos_in = tb_pos_r[j-1] + SUM_W'(term_in);
        assign neg_in = tb_neg_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ta_v_r[j] <= 1'b0;
        tb_v_r[j] <= 1'b0;
      end else begin
        ta_v_r[j] <= v_in;
        tb_v_r[j] <= ta_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      ta_x_r[j]   <= TERM_W'((P_W'(term_in) * P_W'(r_in)) >> rhd_pkg::Q_TERM);
      ta_pos_r[j] <= pos_in;
      ta_neg_r[j] <= neg_in;
      ta_r_r[j]   <= r_in;
      ta_n_r[j]   <= n_in;
      ta_f_r[j]   <= f_in;
      tb_y_r[j]   <= Y_W'(ta_x_r[j]) * Y_W'(rhd_pkg::RECIP_M[j]);
      tb_pos_r[j] <= ta_pos_r[j];
      tb_neg_r[j] <= ta_neg_r[j];
      tb_r_r[j]   <= ta_r_r[j];
      tb_n_r[j]   <= ta_n_r[j];
      tb_f_r[j]   <= ta_f_r[j];
    end
  end

  logic              f1_v_r, f2_v_r, f3_v_r, out_valid_r;
  logic [SUM_W-1:0]  f1_pos_r, f1_neg_r, f2_s_r;
  logic [N_W-1:0]    f1_n_r;
  logic [PR_W-1:0]   f3_res_r;
  rhd_pkg::flags_t   f1_f_r, f2_f_r, f3_f_r;
  logic [rhd_pkg::PCT_W-1:0] out_pct_r;
  logic              out_missing_r;

  logic [TERM_W-1:0] last_term;
  logic [SUM_W-1:0]  s_diff;
  logic [RES_W-1:0]  scaled;
  logic [rhd_pkg::PCT_W-1:0] pct_nxt;
  logic              missing_nxt;

  // The last term has an even index and adds to the positive sum.
  assign last_term = TERM_W'(tb_y_r[T-1] >> rhd_pkg::RECIP_SH[T-1]);
  assign s_diff    = (f1_pos_r > f1_neg_r) ? (f1_pos_r - f1_neg_r) : '0;
  assign scaled    = (RES_W'(f2_s_r) * RES_W'(rhd_pkg::PCT_FULL) +
                      (RES_W'(1) << (rhd_pkg::Q_TERM - 1))) >> rhd_pkg::Q_TERM;

  always_comb begin
    missing_nxt = 1'b0;
    if (f3_f_r.miss) begin
      pct_nxt     = '0;
      missing_nxt = 1'b1;
    end else if (f3_f_r.full) begin
      pct_nxt = rhd_pkg::PCT_FULL;
    end else if (f3_f_r.zero) begin
      pct_nxt = '0;
    end else if (f3_res_r > PR_W'(rhd_pkg::PCT_FULL)) begin
      pct_nxt = rhd_pkg::PCT_FULL;
    end else begin
      pct_nxt = rhd_pkg::PCT_W'(f3_res_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r      <= 1'b0;
      f2_v_r      <= 1'b0;
      f3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f1_v_r      <= tb_v_r[T-1];
      f2_v_r      <= f1_v_r;
      f3_v_r      <= f2_v_r;
      out_valid_r <= f3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_pos_r      <= tb_pos_r[T-1] + SUM_W'(last_term);
    f1_neg_r      <= tb_neg_r[T-1];
    f1_n_r        <= tb_n_r[T-1];
    f1_f_r        <= tb_f_r[T-1];
    f2_s_r        <= s_diff >> f1_n_r;
    f2_f_r        <= f1_f_r;
    f3_res_r      <= PR_W'(scaled);
    f3_f_r        <= f2_f_r;
    out_pct_r     <= pct_nxt;
    out_missing_r <= missing_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pct     = out_pct_r;
  assign out_missing = out_missing_r;

endmodule
`default_nettype wire

>>> src/relative_humidity_from_dewpoint_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relative humidity from dewpoint
// Magnus form relative humidity from air temperature and dewpoint in kelvin.
//
//   Channel  Handshake        Payload
//   input    start / busy     in_temperature_k, in_dewpoint_k, missing flags
//   result   out_valid        out_humidity_percent, out_humidity_missing
//
// One beat is accepted per cycle while busy is low; the two bit-per-stage
// exponent dividers make up most of the pipeline.
// Reset is synchronous and empties the pipeline; busy is high during reset.
// The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module relative_humidity_from_dewpoint_unit #(
  parameter int TEMP_FRAC_BITS = rhd_pkg::TEMP_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [rhd_pkg::IN_W-1:0]   in_temperature_k,
  input  wire logic [rhd_pkg::IN_W-1:0]   in_dewpoint_k,
  input  wire logic                       in_temperature_missing,
  input  wire logic                       in_dewpoint_missing,
  output logic                            out_valid,
  output logic [rhd_pkg::PCT_W-1:0]       out_humidity_percent,
  output logic                            out_humidity_missing
);

  localparam int IN_W  = rhd_pkg::IN_W;
  localparam logic [63:0] KELV = rhd_pkg::kelvin_offset(TEMP_FRAC_BITS);
  localparam logic [63:0] MAGC = rhd_pkg::magnus_offset(TEMP_FRAC_BITS);
  localparam int MAG_W = rhd_pkg::mag_width(TEMP_FRAC_BITS);
  localparam int SW    = MAG_W + 2;
  localparam int PW    = MAG_W + rhd_pkg::A_W;
  localparam int DW    = IN_W + rhd_pkg::SCALE_W;
  localparam int NW    = PW + rhd_pkg::Q_EXP + 1;
  localparam int QW    = rhd_pkg::quo_width(TEMP_FRAC_BITS);
  localparam int EW    = QW + 2;
  localparam int U_W   = rhd_pkg::U_W;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  logic signed [SW-1:0] t_t, t_d, den_t, den_d;
  assign t_t   = $signed(SW'(in_temperature_k)) - $signed(SW'(KELV));
  assign t_d   = $signed(SW'(in_dewpoint_k)) - $signed(SW'(KELV));
  assign den_t = t_t + $signed(SW'(MAGC));
  assign den_d = t_d + $signed(SW'(MAGC));

  logic             s1_v_r, s2_v_r, s3_v_r;
  logic [MAG_W-1:0] s1_mag_t_r, s1_mag_d_r;
  logic [IN_W-1:0]  s1_den_t_r, s1_den_d_r;
  logic             s1_neg_t_r, s1_neg_d_r, s1_miss_r;
  logic [PW-1:0]    s2_p_t_r, s2_p_d_r;
  logic [DW-1:0]    s2_d_t_r, s2_d_d_r, s3_d_t_r, s3_d_d_r;
  logic             s2_neg_t_r, s2_neg_d_r, s2_miss_r;
  logic [NW-1:0]    s3_n_t_r, s3_n_d_r;
  logic             s3_neg_t_r, s3_neg_d_r, s3_miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag_t_r <= t_t[SW-1] ? MAG_W'(-t_t) : MAG_W'(t_t);
    s1_mag_d_r <= t_d[SW-1] ? MAG_W'(-t_d) : MAG_W'(t_d);
    s1_neg_t_r <= t_t[SW-1];
    s1_neg_d_r <= t_d[SW-1];
    s1_den_t_r <= IN_W'(den_t);
    s1_den_d_r <= IN_W'(den_d);
    s1_miss_r  <= in_temperature_missing | in_dewpoint_missing |
                  (den_t <= 0) | (den_d <= 0);

    s2_p_t_r   <= PW'(s1_mag_t_r) * PW'(rhd_pkg::MAGNUS_A_X100);
    s2_p_d_r   <= PW'(s1_mag_d_r) * PW'(rhd_pkg::MAGNUS_A_X100);
    s2_d_t_r   <= DW'(s1_den_t_r) * DW'(rhd_pkg::SCALE);
    s2_d_d_r   <= DW'(s1_den_d_r) * DW'(rhd_pkg::SCALE);
    s2_neg_t_r <= s1_neg_t_r;
    s2_neg_d_r <= s1_neg_d_r;
    s2_miss_r  <= s1_miss_r;

    s3_n_t_r   <= (NW'(s2_p_t_r) << rhd_pkg::Q_EXP) + NW'(s2_d_t_r >> 1);
    s3_n_d_r   <= (NW'(s2_p_d_r) << rhd_pkg::Q_EXP) + NW'(s2_d_d_r >> 1);
    s3_d_t_r   <= s2_d_t_r;
    s3_d_d_r   <= s2_d_d_r;
    s3_neg_t_r <= s2_neg_t_r;
    s3_neg_d_r <= s2_neg_d_r;
    s3_miss_r  <= s2_miss_r;
  end

  logic          dv_t, dv_d;
  logic [QW-1:0] q_t, q_d;
  logic [1:0]    tag_t;
  logic [0:0]    tag_d;

  rhd_div #(.NW(NW), .DW(DW), .QW(QW), .TW(2)) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_num    (s3_n_t_r),
    .in_den    (s3_d_t_r),
    .in_tag    ({s3_miss_r, s3_neg_t_r}),
    .out_valid (dv_t),
    .out_quo   (q_t),
    .out_tag   (tag_t)
  );

  rhd_div #(.NW(NW), .DW(DW), .QW(QW), .TW(1)) u_div_d (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_num    (s3_n_d_r),
    .in_den    (s3_d_d_r),
    .in_tag    (s3_neg_d_r),
    .out_valid (dv_d),
    .out_quo   (q_d),
    .out_tag   (tag_d)
  );

  logic signed [EW-1:0] e_t, e_d;
  assign e_t = tag_t[0] ? -$signed(EW'(q_t)) : $signed(EW'(q_t));
  assign e_d = tag_d[0] ? -$signed(EW'(q_d)) : $signed(EW'(q_d));

  logic                 d1_v_r, d2_v_r;
  logic signed [EW-1:0] d1_diff_r;
  logic                 d1_miss_r;
  logic [U_W-1:0]       d2_u_r;
  rhd_pkg::flags_t      d2_f_r;
  logic [EW-1:0]        u_full;

  assign u_full = EW'(-d1_diff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
    end else begin
      d1_v_r <= dv_t & dv_d;
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_diff_r   <= e_d - e_t;
    d1_miss_r   <= tag_t[1];
    d2_u_r      <= u_full[U_W-1:0];
    d2_f_r.miss <= d1_miss_r;
    d2_f_r.full <= ~d1_diff_r[EW-1];
    d2_f_r.zero <= d1_diff_r[EW-1] & (u_full >= (EW'(1) << U_W));
  end

  rhd_exp u_exp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (d2_v_r),
    .in_u        (d2_u_r),
    .in_flags    (d2_f_r),
    .out_valid   (out_valid),
    .out_pct     (out_humidity_percent),
    .out_missing (out_humidity_missing)
  );

endmodule
`default_nettype wire

>>> src/rhd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relative humidity checker
// Port level properties of the relative humidity unit, bound to the top.
// ----------------------------------------------------------------------------
module rhd_checker #(
  parameter int LAT = 85
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [rhd_pkg::IN_W-1:0] in_temperature_k,
  input wire logic [rhd_pkg::IN_W-1:0] in_dewpoint_k,
  input wire logic                     in_temperature_missing,
  input wire logic                     in_dewpoint_missing,
  input wire logic                     out_valid,
  input wire logic [rhd_pkg::PCT_W-1:0] out_humidity_percent,
  input wire logic                     out_humidity_missing
);

  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_humidity_missing) |-> (out_humidity_percent == '0))
    else $error("missing result with nonzero humidity");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_percent <= rhd_pkg::PCT_FULL))
    else $error("humidity above full scale");

  a_missing_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_temperature_missing || in_dewpoint_missing))
      |-> ##LAT (out_valid && out_humidity_missing))
    else $error("missing input beat not answered after pipeline latency");

endmodule

bind relative_humidity_from_dewpoint_unit rhd_checker #(
  .LAT(rhd_pkg::latency(TEMP_FRAC_BITS))
) u_rhd_checker (.*);
`default_nettype wire
